### hw/rtl/fed_pkg.sv
// ============================================================================
// fed_pkg: shared definitions for the feedback echo delay
// Default sizes, gain constants and configuration register codes.
// ============================================================================
`default_nettype none

package fed_pkg;

  // Default sizes
  localparam int MAX_FRAMES_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register field widths
  localparam int DELAY_W = 17;
  localparam int GAIN_W  = 8;

  // Full-scale gain (unity is 255/255)
  localparam logic [GAIN_W-1:0] GAIN_MAX = 8'd255;

  // APB bus
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // Configuration register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_DELAY_FRAMES  = 3'd0,
    REG_WET_GAIN      = 3'd1,
    REG_STORE_GAIN    = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_STEREO_MODE   = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

### hw/rtl/fed_if.sv
// ============================================================================
// fed_if: stream channels of the feedback echo delay
// Frame request channel (input samples) and mixed-frame result channel.
// ============================================================================
`default_nettype none

interface fed_in_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          block_last;

  modport source (output valid, left_sample, right_sample, block_last, input ready);
  modport sink   (input valid, left_sample, right_sample, block_last, output ready);
endinterface

interface fed_out_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_last_out;

  modport source (output valid, left_out, right_out, block_last_out, input ready);
  modport sink   (input valid, left_out, right_out, block_last_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/feedback_echo_delay.sv
// ============================================================================
// feedback_echo_delay: stereo feedback echo over a circular delay memory
// Pipeline: read at request accept (stage A), multiply (stage B),
//   divide-by-255 (stage C), then sum/saturate into the output register.
// Throughput: one frame per cycle while the output is not stalled and the
//   effective delay is 4 frames or more; a shorter delay holds requests at the
//   interlock on the single delay memory's read-modify-write of the same entry.
// Reset: synchronous, active low; config returns to defaults, position and
//   fill count clear, so unvisited entries read as zero with no clearing pass.
// ============================================================================
`default_nettype none

module feedback_echo_delay #(
  parameter int MAX_FRAMES  = fed_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  fed_in_if.sink                          in_frame,
  fed_out_if.source                       out_frame,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fed_pkg::APB_AW-1:0] paddr,
  input  wire logic [fed_pkg::APB_DW-1:0] pwdata,
  output logic      [fed_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import fed_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
  localparam int PW = SB + 9;     // sample x 9-bit signed gain
  localparam int RW = PW + 41;    // reciprocal product width

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [PW-1:0] mul_gain(input logic signed [SB-1:0] x,
                                                    input logic [GAIN_W-1:0] g);
    logic signed [GAIN_W:0] gs;
    gs = $signed({1'b0, g});
    return PW'(x) * PW'(gs);
  endfunction

  // round(p / 255), ties away from zero; division by reciprocal
  // 0x0101010102 / 2^40, exact for magnitudes under 2^32
  function automatic logic signed [SB-1:0] gain_round(input logic signed [PW-1:0] p);
    logic          neg;
    logic [PW-1:0] mag;
    logic [PW-1:0] n;
    logic [RW-1:0] nx;
    logic [RW-1:0] prod;
    logic [SB-1:0] q;
    neg  = p[PW-1];
    mag  = neg ? PW'(-p) : PW'(p);
    n    = mag + PW'(127);
    nx   = RW'(n);
    prod = (nx << 32) + (nx << 24) + (nx << 16) + (nx << 8) + (nx << 1);
    q    = prod[40 +: SB];
    return neg ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    s = (SB+1)'(a) + (SB+1)'(b);
    if (s[SB] != s[SB-1]) begin
      return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    return s[SB-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers (APB)
  // --------------------------------------------------------------------------
  logic [DELAY_W-1:0] delay_frames_r;
  logic [GAIN_W-1:0]  wet_gain_r;
  logic [GAIN_W-1:0]  store_gain_r;
  logic [GAIN_W-1:0]  feedback_gain_r;
  logic               stereo_mode_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_frames_r  <= DELAY_W'(1);
      wet_gain_r      <= '0;
      store_gain_r    <= '0;
      feedback_gain_r <= '0;
      stereo_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DELAY_FRAMES:  delay_frames_r  <= pwdata[DELAY_W-1:0];
        REG_WET_GAIN:      wet_gain_r      <= pwdata[GAIN_W-1:0];
        REG_STORE_GAIN:    store_gain_r    <= pwdata[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= pwdata[GAIN_W-1:0];
        REG_STEREO_MODE:   stereo_mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_DELAY_FRAMES:  prdata = APB_DW'(delay_frames_r);
      REG_WET_GAIN:      prdata = APB_DW'(wet_gain_r);
      REG_STORE_GAIN:    prdata = APB_DW'(store_gain_r);
      REG_FEEDBACK_GAIN: prdata = APB_DW'(feedback_gain_r);
      REG_STEREO_MODE:   prdata = APB_DW'(stereo_mode_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Position and fill tracking
  // --------------------------------------------------------------------------
  logic [LW-1:0] delay_ext;
  logic [LW-1:0] len_eff;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_eff;
  logic [LW-1:0] pos_inc;
  logic [AW-1:0] pos_nxt;
  logic [AW:0]   fill_r;
  logic [AW:0]   fill_nxt;
  logic          entry_hit;

  // Clamp length to 1..MAX_FRAMES
  assign delay_ext = LW'(delay_frames_r);
  assign len_eff   = (delay_ext == '0)              ? LW'(1) :
                     (delay_ext > LW'(MAX_FRAMES))  ? LW'(MAX_FRAMES) : delay_ext;

  // Position out of range after a shortened length restarts at zero
  assign pos_eff = (LW'(pos_r) >= len_eff) ? '0 : pos_r;
  assign pos_inc = LW'(pos_eff) + LW'(1);
  assign pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

  // Visited entries always form a prefix, so one count marks them written
  assign entry_hit = (AW+1)'(pos_eff) < fill_r;
  assign fill_nxt  = ((AW+1)'(pos_eff) == fill_r) ? fill_r + (AW+1)'(1) : fill_r;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic hazard;
  logic in_acc;
  logic wr_en;

  logic a_valid_r, b_valid_r, c_valid_r;
  logic [AW-1:0] a_pos_r, b_pos_r, c_pos_r;

  assign adv = !out_valid_r || out_frame.ready;

  // Interlock: entry still being modified by a request in flight
  assign hazard = (a_valid_r && (a_pos_r == pos_eff)) ||
                  (b_valid_r && (b_pos_r == pos_eff)) ||
                  (c_valid_r && (c_pos_r == pos_eff));

  assign in_frame.ready = adv && !hazard;
  assign in_acc         = in_frame.valid && in_frame.ready;
  assign wr_en          = c_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Delay memory: {right, left} per frame
  // --------------------------------------------------------------------------
  logic [2*SB-1:0] mem [MAX_FRAMES];
  logic [2*SB-1:0] mem_q_r;
  logic [2*SB-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[c_pos_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r <= mem[pos_eff];
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: request and delayed samples
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] a_left_r, a_right_r;
  logic                 a_last_r, a_hit_r;
  logic signed [SB-1:0] dl_left, dl_right;
  logic [GAIN_W-1:0]    dry_gain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pos_r   <= pos_eff;
      a_left_r  <= in_frame.left_sample;
      a_right_r <= in_frame.right_sample;
      a_last_r  <= in_frame.block_last;
      a_hit_r   <= entry_hit;
    end
  end

  // Never-written entries read as zero
  assign dl_left  = a_hit_r ? $signed(mem_q_r[SB-1:0])    : '0;
  assign dl_right = a_hit_r ? $signed(mem_q_r[2*SB-1:SB]) : '0;
  assign dry_gain = GAIN_MAX - wet_gain_r;

  // --------------------------------------------------------------------------
  // Stage B: gain products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] b_ls_r, b_lf_r, b_ld_r, b_lw_r;
  logic signed [PW-1:0] b_rs_r, b_rf_r, b_rd_r, b_rw_r;
  logic signed [SB-1:0] b_old_right_r;
  logic                 b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pos_r       <= a_pos_r;
      b_last_r      <= a_last_r;
      b_old_right_r <= dl_right;
      b_ls_r        <= mul_gain(a_left_r, store_gain_r);
      b_lf_r        <= mul_gain(dl_left, feedback_gain_r);
      b_ld_r        <= mul_gain(a_left_r, dry_gain);
      b_lw_r        <= mul_gain(dl_left, wet_gain_r);
      b_rs_r        <= mul_gain(a_right_r, store_gain_r);
      b_rf_r        <= mul_gain(dl_right, feedback_gain_r);
      b_rd_r        <= mul_gain(a_right_r, dry_gain);
      b_rw_r        <= mul_gain(dl_right, wet_gain_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: rounded divide by 255
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] c_ls_r, c_lf_r, c_ld_r, c_lw_r;
  logic signed [SB-1:0] c_rs_r, c_rf_r, c_rd_r, c_rw_r;
  logic signed [SB-1:0] c_old_right_r;
  logic                 c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pos_r       <= b_pos_r;
      c_last_r      <= b_last_r;
      c_old_right_r <= b_old_right_r;
      c_ls_r        <= gain_round(b_ls_r);
      c_lf_r        <= gain_round(b_lf_r);
      c_ld_r        <= gain_round(b_ld_r);
      c_lw_r        <= gain_round(b_lw_r);
      c_rs_r        <= gain_round(b_rs_r);
      c_rf_r        <= gain_round(b_rf_r);
      c_rd_r        <= gain_round(b_rd_r);
      c_rw_r        <= gain_round(b_rw_r);
    end
  end

  // --------------------------------------------------------------------------
  // Saturating sums, write-back and result register
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] wb_left, wb_right, mix_left, mix_right;
  logic signed [SB-1:0] out_left_r, out_right_r;
  logic                 out_last_r;

  assign wb_left   = sat_add(c_ls_r, c_lf_r);
  assign wb_right  = sat_add(c_rs_r, c_rf_r);
  assign mix_left  = sat_add(c_ld_r, c_lw_r);
  assign mix_right = sat_add(c_rd_r, c_rw_r);

  // Mono keeps the right half of the entry as it was
  assign wr_data = {(stereo_mode_r ? wb_right : c_old_right_r), wb_left};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_left_r  <= mix_left;
      out_right_r <= stereo_mode_r ? mix_right : '0;
      out_last_r  <= c_last_r;
    end
  end

  assign out_frame.valid          = out_valid_r;
  assign out_frame.left_out       = out_left_r;
  assign out_frame.right_out      = out_right_r;
  assign out_frame.block_last_out = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A new read never hits the entry being written back in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wr_en) |-> (pos_eff != c_pos_r))
    else $error("read and write-back of the same delay entry collide");

  // Fill count stays within the memory
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (AW+1)'(MAX_FRAMES))
    else $error("fill count beyond memory depth");

  // Position stays inside the delay length after each request
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (LW'(pos_r) < len_eff))
    else $error("write position outside delay length");

  // Every position handed to the pipeline lies in the written prefix or extends it
  a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((AW+1)'(pos_eff) <= fill_r))
    else $error("delay position skips past fill count");

endmodule

`default_nettype wire
